@@ src/crlf_pkg.sv @@
// shared constants and types for the crlf line framer
// depends on nothing; used by crlf_line_framer
package crlf_pkg;

    // line store sizing: LINE_DEPTH-1 characters, LINE_DEPTH in 2..64
    localparam int LINE_DEPTH  = 64;
    localparam int STORE_DEPTH = LINE_DEPTH - 1;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // length and index fields are fixed at six bits
    localparam int LEN_W = 6;

    // line terminators
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

@@ src/crlf_line_framer.sv @@
// Order: a committing terminator clears the read index and moves the sequencer to emit; the first
// character is then read from the line store into the output register. Input: one byte per cycle
// while idle; a committed line holds input stalled until its last character is read from the store.
// Store reads and output run at one character per cycle unless out_stall holds them.
// Reset: line length, discard flag and both counters clear at once, the sequencer returns to idle;
// the line store is not cleared, entries are written before they are read.
module crlf_line_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  line_char,
    output logic [5:0]  char_index,
    output logic [5:0]  line_length,
    output logic        is_last,
    output logic [31:0] frame_count,
    output logic [31:0] frame_time_ms,
    output logic [31:0] overflow_count
);

    localparam logic [crlf_pkg::LEN_W-1:0] STORE_FULL =
        crlf_pkg::LEN_W'(crlf_pkg::STORE_DEPTH);
    localparam logic [crlf_pkg::LEN_W-1:0] LEN_ONE = crlf_pkg::LEN_W'(1);

    // line store memory
    logic [7:0] line_store_mem [crlf_pkg::STORE_DEPTH];

    // control state
    crlf_pkg::state_t state_reg, state_next;
    logic [crlf_pkg::LEN_W-1:0] line_len_reg, line_len_next;
    logic                       discard_reg, discard_next;
    logic [31:0]                frame_cnt_reg, frame_cnt_next;
    logic [31:0]                ovf_cnt_reg, ovf_cnt_next;
    logic [crlf_pkg::LEN_W-1:0] rd_idx_reg, rd_idx_next;
    logic                       out_valid_reg, out_valid_next;

    // payload held for the line being emitted
    logic [crlf_pkg::LEN_W-1:0] job_len_reg;
    logic [31:0]                job_time_reg;

    // output payload
    logic [7:0]                 out_char_reg;
    logic [crlf_pkg::LEN_W-1:0] out_idx_reg;
    logic [crlf_pkg::LEN_W-1:0] out_len_reg;
    logic                       out_last_reg;
    logic [31:0]                out_frame_reg;
    logic [31:0]                out_time_reg;
    logic [31:0]                out_ovf_reg;

    logic in_fire;
    logic out_fire;
    logic is_term;
    logic commit;
    logic append;
    logic overflow;
    logic issue;
    logic issue_last;

    // request decode
    assign is_term  = (rx_byte == crlf_pkg::CHAR_CR) || (rx_byte == crlf_pkg::CHAR_LF);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign commit   = in_fire && is_term && (line_len_reg != '0) && !discard_reg;
    assign append   = in_fire && !is_term && !discard_reg && (line_len_reg < STORE_FULL);
    assign overflow = in_fire && !is_term && !discard_reg && (line_len_reg >= STORE_FULL);
    assign issue_last = (rd_idx_reg == (job_len_reg - LEN_ONE));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crlf_pkg::ST_IDLE:
            begin
                if (commit)
                begin
                    state_next = crlf_pkg::ST_EMIT;
                end
            end
            crlf_pkg::ST_EMIT:
            begin
                if (issue && issue_last)
                begin
                    state_next = crlf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crlf_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs: input stall and store read issue
    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        case (state_reg)
            crlf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            crlf_pkg::ST_EMIT:
            begin
                issue = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // line bookkeeping and counters
    always_comb
    begin
        line_len_next  = line_len_reg;
        discard_next   = discard_reg;
        frame_cnt_next = frame_cnt_reg;
        ovf_cnt_next   = ovf_cnt_reg;
        if (in_fire && is_term)
        begin
            line_len_next = '0;
            discard_next  = 1'b0;
        end
        if (commit)
        begin
            frame_cnt_next = frame_cnt_reg + 32'd1;
        end
        if (append)
        begin
            line_len_next = line_len_reg + LEN_ONE;
        end
        if (overflow)
        begin
            ovf_cnt_next  = ovf_cnt_reg + 32'd1;
            line_len_next = '0;
            discard_next  = 1'b1;
        end
    end

    // read index and output valid
    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            rd_idx_next = '0;
        end
        else if (issue)
        begin
            rd_idx_next = rd_idx_reg + LEN_ONE;
        end
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crlf_pkg::ST_IDLE;
            line_len_reg  <= '0;
            discard_reg   <= 1'b0;
            frame_cnt_reg <= '0;
            ovf_cnt_reg   <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_len_reg  <= line_len_next;
            discard_reg   <= discard_next;
            frame_cnt_reg <= frame_cnt_next;
            ovf_cnt_reg   <= ovf_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // line store write port
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            line_store_mem[line_len_reg[crlf_pkg::ADDR_W-1:0]] <= rx_byte;
        end
    end

    // line store read port and output payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            job_len_reg  <= line_len_reg;
            job_time_reg <= now_ms;
        end
        if (issue)
        begin
            out_char_reg  <= line_store_mem[rd_idx_reg[crlf_pkg::ADDR_W-1:0]];
            out_idx_reg   <= rd_idx_reg;
            out_len_reg   <= job_len_reg;
            out_last_reg  <= issue_last;
            out_frame_reg <= frame_cnt_reg;
            out_time_reg  <= job_time_reg;
            out_ovf_reg   <= ovf_cnt_reg;
        end
    end

    // output ports
    assign out_valid      = out_valid_reg;
    assign line_char      = out_char_reg;
    assign char_index     = out_idx_reg;
    assign line_length    = out_len_reg;
    assign is_last        = out_last_reg;
    assign frame_count    = out_frame_reg;
    assign frame_time_ms  = out_time_reg;
    assign overflow_count = out_ovf_reg;

`ifndef SYNTHESIS
    // the line never grows past the store
    assert property (@(posedge clk) disable iff (!rst_n)
        line_len_reg <= STORE_FULL)
        else $error("line length beyond store depth");

    // a discarded line holds no characters
    assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (line_len_reg == '0))
        else $error("discard with stored characters");

    // every store read stays inside the committed line
    assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (rd_idx_reg < job_len_reg))
        else $error("store read beyond line length");

    // the last mark sits on the final character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_idx_reg == (out_len_reg - LEN_ONE)))
        else $error("last mark off the final character");

    // a committed line goes out starting at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (rd_idx_reg == '0) && (state_reg == crlf_pkg::ST_EMIT))
        else $error("emit did not start at first character");
`endif

endmodule
